// ===== hdl/mwm_pkg.sv =====
// ----------------------------------------------------------------------------
// mwm_pkg
// Shared types and constants for the mecanum wheel mixer pipeline.
// ----------------------------------------------------------------------------
package mwm_pkg;

	localparam int NUM_WHEELS = 4;
	localparam int CMD_W      = 16;
	localparam int LIMIT_W    = 15;
	localparam int RAW_W      = 18;   // sum of three 16-bit signed values
	localparam int MAG_W      = 17;   // magnitude of a raw wheel speed
	localparam int PROD_W     = MAG_W + LIMIT_W;
	localparam int QUO_W      = LIMIT_W; // quotient never exceeds the limit
	localparam int DIV_STEPS  = QUO_W;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd6270;

	// chassis command beat
	typedef struct packed {
		logic signed [CMD_W-1:0] vel_forward;
		logic signed [CMD_W-1:0] vel_sideways;
		logic signed [CMD_W-1:0] rot_rate;
	} cmd_t;

	// wheel speed result beat
	typedef struct packed {
		logic signed [CMD_W-1:0] wheel_one;
		logic signed [CMD_W-1:0] wheel_two;
		logic signed [CMD_W-1:0] wheel_three;
		logic signed [CMD_W-1:0] wheel_four;
		logic                    was_scaled;
	} wheels_t;

	// mixer front end output: magnitudes, signs and peak
	typedef struct packed {
		logic [NUM_WHEELS-1:0][MAG_W-1:0] mag;
		logic [NUM_WHEELS-1:0]            neg;
		logic [NUM_WHEELS-1:0][CMD_W-1:0] raw;
		logic [MAG_W-1:0]                 peak;
		logic                             scale;
		logic [LIMIT_W-1:0]               limit;
	} mix_t;

	// sideband that rides beside the divider lanes
	typedef struct packed {
		logic [NUM_WHEELS-1:0]            neg;
		logic [NUM_WHEELS-1:0][CMD_W-1:0] raw;
		logic                             scale;
	} side_t;

endpackage

// ===== hdl/mwm_mix.sv =====
// ----------------------------------------------------------------------------
// mwm_mix
// Three-stage front end: wheel sums, magnitudes, peak search and limit check.
// ----------------------------------------------------------------------------
module mwm_mix (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  mwm_pkg::cmd_t                cmd,
	input  logic [mwm_pkg::LIMIT_W-1:0]  limit,
	output logic                         out_vld,
	output mwm_pkg::mix_t                mix
);
	import mwm_pkg::*;

	logic                                  vld_s1, vld_s2, vld_s3;
	logic signed [NUM_WHEELS-1:0][RAW_W-1:0] raw_s1;
	logic [LIMIT_W-1:0]                    limit_s1, limit_s2;
	logic [NUM_WHEELS-1:0][MAG_W-1:0]      mag_s2;
	logic [NUM_WHEELS-1:0]                 neg_s2;
	logic [NUM_WHEELS-1:0][CMD_W-1:0]      raw_s2;
	logic [MAG_W-1:0]                      max01_s2, max23_s2;
	mix_t                                  mix_s3;

	logic signed [RAW_W-1:0]               fwd, side, rot;
	logic [NUM_WHEELS-1:0][MAG_W-1:0]      mag;
	logic [MAG_W-1:0]                      peak;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage 1: raw wheel sums
	assign fwd  = RAW_W'(cmd.vel_forward);
	assign side = RAW_W'(cmd.vel_sideways);
	assign rot  = RAW_W'(cmd.rot_rate);

	always_ff @(posedge clk) begin
		raw_s1[0] <=  fwd - side + rot;
		raw_s1[1] <=  fwd + side + rot;
		raw_s1[2] <= -fwd + side + rot;
		raw_s1[3] <= -fwd - side + rot;
		limit_s1  <= limit;
	end

	// stage 2: magnitudes and pairwise maxima
	always_comb begin
		for (int i = 0; i < NUM_WHEELS; i++) begin
			if (raw_s1[i][RAW_W-1])
				mag[i] = MAG_W'(-raw_s1[i]);
			else
				mag[i] = MAG_W'(raw_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_WHEELS; i++) begin
			mag_s2[i] <= mag[i];
			neg_s2[i] <= raw_s1[i][RAW_W-1];
			raw_s2[i] <= raw_s1[i][CMD_W-1:0];
		end
		max01_s2 <= (mag[0] > mag[1]) ? mag[0] : mag[1];
		max23_s2 <= (mag[2] > mag[3]) ? mag[2] : mag[3];
		limit_s2 <= limit_s1;
	end

	// stage 3: peak and limit compare
	assign peak = (max01_s2 > max23_s2) ? max01_s2 : max23_s2;

	always_ff @(posedge clk) begin
		mix_s3.mag   <= mag_s2;
		mix_s3.neg   <= neg_s2;
		mix_s3.raw   <= raw_s2;
		mix_s3.peak  <= peak;
		mix_s3.scale <= peak > MAG_W'(limit_s2);
		mix_s3.limit <= limit_s2;
	end

	assign out_vld = vld_s3;
	assign mix     = mix_s3;

endmodule

// ===== hdl/mwm_div.sv =====
// ----------------------------------------------------------------------------
// mwm_div
// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees the quotient fits in QUO_W bits (dividend < divisor * 2^QUO_W).
// ----------------------------------------------------------------------------
module mwm_div (
	input  logic                        clk,
	input  logic [mwm_pkg::PROD_W-1:0]  dividend,
	input  logic [mwm_pkg::MAG_W-1:0]   divisor,
	output logic [mwm_pkg::QUO_W-1:0]   quotient
);
	import mwm_pkg::*;

	// index 0 is the unregistered input, index k the output of stage k
	logic [MAG_W-1:0] rem_s [DIV_STEPS+1];
	logic [QUO_W-1:0] low_s [DIV_STEPS+1];
	logic [MAG_W-1:0] dvs_s [DIV_STEPS+1];

	// upper bits start the partial remainder, lower bits shift in one a step
	assign rem_s[0] = dividend[PROD_W-1:QUO_W];
	assign low_s[0] = dividend[QUO_W-1:0];
	assign dvs_s[0] = divisor;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [MAG_W:0]   trial;
		logic [MAG_W-1:0] diff;
		logic             ge;

		// compare and subtract for one quotient bit
		always_comb begin
			trial = {rem_s[k], low_s[k][QUO_W-1]};
			diff  = trial[MAG_W-1:0] - dvs_s[k];
			ge    = trial >= {1'b0, dvs_s[k]};
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? diff : trial[MAG_W-1:0];
			low_s[k+1] <= {low_s[k][QUO_W-2:0], ge};
			dvs_s[k+1] <= dvs_s[k];
		end
	end

	assign quotient = low_s[DIV_STEPS];

endmodule

// ===== hdl/mecanum_wheel_mixer.sv =====
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer
// Mixes a chassis command into four mecanum wheel speeds and scales them
// proportionally down to the configured wheel limit when the peak exceeds it.
//
// channel   direction  handshake            payload
// command   in         start / busy         cmd (cmd_t)
// result    out        done strobe          wheels (wheels_t)
// config    in         cfg_valid/cfg_ready  cfg_data (wheel speed limit)
//
// One command beat enters every cycle; each result passes through three
// front-end stages, one multiply stage, fifteen divider stages (one quotient
// bit each) and the output register. busy is always low and cfg_ready
// always high. Reset clears the valid bits and loads the limit with 6270.
// Results are strobed for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  mwm_pkg::cmd_t                cmd,
	output logic                         done,
	output mwm_pkg::wheels_t             wheels,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [mwm_pkg::LIMIT_W-1:0]  cfg_data
);
	import mwm_pkg::*;

	logic [LIMIT_W-1:0]                 limit_q;
	logic                               mix_vld;
	mix_t                               mix;
	logic                               vld_s4;
	logic [NUM_WHEELS-1:0][PROD_W-1:0]  prod_s4;
	logic [MAG_W-1:0]                   peak_s4;
	side_t                              side_s4;
	logic                               vld_dq  [DIV_STEPS];
	side_t                              side_dq [DIV_STEPS];
	logic [NUM_WHEELS-1:0][QUO_W-1:0]   quo;
	logic [NUM_WHEELS-1:0][CMD_W-1:0]   speed;
	wheels_t                            wheels_q;
	logic                               done_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= LIMIT_RESET;
		else if (cfg_valid && cfg_ready)
			limit_q <= cfg_data;
	end

	// sums, magnitudes and peak
	mwm_mix u_mix (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start && !busy),
		.cmd     (cmd),
		.limit   (limit_q),
		.out_vld (mix_vld),
		.mix     (mix)
	);

	// stage 4: magnitude times limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else
			vld_s4 <= mix_vld;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_WHEELS; i++)
			prod_s4[i] <= PROD_W'(mix.mag[i]) * PROD_W'(mix.limit);
		peak_s4       <= mix.peak;
		side_s4.neg   <= mix.neg;
		side_s4.raw   <= mix.raw;
		side_s4.scale <= mix.scale;
	end

	// divider lanes
	for (genvar w = 0; w < NUM_WHEELS; w++) begin : g_lane
		mwm_div u_div (
			.clk      (clk),
			.dividend (prod_s4[w]),
			.divisor  (peak_s4),
			.quotient (quo[w])
		);
	end

	// sideband delay matched to the divider depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STEPS; k++)
				vld_dq[k] <= 1'b0;
		end else begin
			vld_dq[0] <= vld_s4;
			for (int k = 1; k < DIV_STEPS; k++)
				vld_dq[k] <= vld_dq[k-1];
		end
	end

	always_ff @(posedge clk) begin
		side_dq[0] <= side_s4;
		for (int k = 1; k < DIV_STEPS; k++)
			side_dq[k] <= side_dq[k-1];
	end

	// sign restore and choice of scaled or raw speed
	always_comb begin
		for (int i = 0; i < NUM_WHEELS; i++) begin
			if (!side_dq[DIV_STEPS-1].scale)
				speed[i] = side_dq[DIV_STEPS-1].raw[i];
			else if (side_dq[DIV_STEPS-1].neg[i])
				speed[i] = -{1'b0, quo[i]};
			else
				speed[i] = {1'b0, quo[i]};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= vld_dq[DIV_STEPS-1];
	end

	always_ff @(posedge clk) begin
		wheels_q.wheel_one   <= speed[0];
		wheels_q.wheel_two   <= speed[1];
		wheels_q.wheel_three <= speed[2];
		wheels_q.wheel_four  <= speed[3];
		wheels_q.was_scaled  <= side_dq[DIV_STEPS-1].scale;
	end

	assign done   = done_q;
	assign wheels = wheels_q;

endmodule

// ===== tb/mecanum_wheel_mixer_tb.sv =====
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer_tb
// Drives chassis commands into the mixer under several wheel limits and
// idle patterns, and compares every strobed result with a typed value or an
// in-bench model of the mixing and proportional scaling.
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer_tb;

	import mwm_pkg::*;

	localparam int PIPE_DEPTH   = 20;   // command to result latency
	localparam int STALL_LIMIT  = 2000; // cycles without any beat
	localparam int NUM_PHASES   = 5;
	localparam int PHASE_CMDS   = 240;
	localparam int NUM_DIRECTED = 21;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	cmd_t                cmd;
	logic                done;
	wheels_t             wheels;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [LIMIT_W-1:0]  cfg_data;

	// limit the model applies, tracks register writes
	logic [LIMIT_W-1:0]  cur_limit;
	wheels_t             pending_wheels[$];
	int                  n_cmds;
	int                  n_results;
	int                  n_scaled;
	int                  n_limits;
	int                  n_errors;
	int                  quiet_cycles;

	// directed rows: limit, command, and the result where it is obvious
	typedef struct {
		int lim;
		int fwd;
		int side;
		int rot;
		bit known;
		int w1;
		int w2;
		int w3;
		int w4;
		bit sc;
	} dir_row_t;

	dir_row_t dir_tab [NUM_DIRECTED] = '{
		'{6270,      0,      0,      0, 1,     0,     0,     0,     0, 0},
		'{6270,    100,      0,      0, 1,   100,   100,  -100,  -100, 0},
		'{6270,      0,    100,      0, 1,  -100,   100,   100,  -100, 0},
		'{6270,      0,      0,    100, 1,   100,   100,   100,   100, 0},
		'{6270,   6270,      0,      0, 1,  6270,  6270, -6270, -6270, 0},
		'{6270,   6271,      0,      0, 1,  6270,  6270, -6270, -6270, 1},
		'{6270,  32767,  32767,  32767, 0,     0,     0,     0,     0, 0},
		'{6270, -32768, -32768, -32768, 0,     0,     0,     0,     0, 0},
		'{6270, -32768,  32767, -32768, 0,     0,     0,     0,     0, 0},
		'{6270,  32767, -32768,  32767, 0,     0,     0,     0,     0, 0},
		'{6270,   1000,  -2000,   3000, 0,     0,     0,     0,     0, 0},
		'{32767, 32767,      0,      0, 1, 32767, 32767,-32767,-32767, 0},
		'{32767,-32768,      0,      0, 1,-32767,-32767, 32767, 32767, 1},
		'{32767,-32768, -32768, -32768, 0,     0,     0,     0,     0, 0},
		'{32767, 32767,  32767, -32768, 0,     0,     0,     0,     0, 0},
		'{0,         0,      0,      0, 1,     0,     0,     0,     0, 0},
		'{0,         1,      0,      0, 1,     0,     0,     0,     0, 1},
		'{0,    -32768,  32767,     -1, 1,     0,     0,     0,     0, 1},
		'{1,         1,      0,      0, 1,     1,     1,    -1,    -1, 0},
		'{1,         3,      2,      1, 0,     0,     0,     0,     0, 0},
		'{1,    -32768, -32768,  32767, 0,     0,     0,     0,     0, 0}
	};

	int idle_pct [NUM_PHASES] = '{0, 48, 26, 48, 0};

	mecanum_wheel_mixer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.wheels    (wheels),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// wheel mixing and proportional limiting
	function automatic wheels_t mix_wheels(cmd_t c, logic [LIMIT_W-1:0] lim);
		int      f;
		int      s;
		int      r;
		int      l;
		int      raw [NUM_WHEELS];
		int      mag [NUM_WHEELS];
		int      peak;
		longint  q;
		int      v [NUM_WHEELS];
		wheels_t w;
		f = c.vel_forward;
		s = c.vel_sideways;
		r = c.rot_rate;
		l = lim;
		raw[0] = f - s + r;
		raw[1] = f + s + r;
		raw[2] = -f + s + r;
		raw[3] = -f - s + r;
		peak = 0;
		for (int i = 0; i < NUM_WHEELS; i++) begin
			mag[i] = (raw[i] < 0) ? -raw[i] : raw[i];
			if (mag[i] > peak)
				peak = mag[i];
		end
		w.was_scaled = (peak > l);
		for (int i = 0; i < NUM_WHEELS; i++) begin
			v[i] = raw[i];
			if (w.was_scaled) begin
				q = (longint'(mag[i]) * l) / peak;
				v[i] = (raw[i] < 0) ? -int'(q) : int'(q);
			end
		end
		w.wheel_one   = v[0][CMD_W-1:0];
		w.wheel_two   = v[1][CMD_W-1:0];
		w.wheel_three = v[2][CMD_W-1:0];
		w.wheel_four  = v[3][CMD_W-1:0];
		return w;
	endfunction

	// one velocity field: extremes, zero, values within about a third of the limit, or anything
	function automatic logic signed [CMD_W-1:0] pick_vel(int lim);
		int span;
		span = lim / 3 + 1;
		case ($urandom_range(0, 9)) inside
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return '0;
			[3:5]: return CMD_W'(int'($urandom_range(0, 2 * span)) - span);
			default: return CMD_W'($urandom);
		endcase
	endfunction

	task automatic check_field(string name, int expv, int actv);
		if (expv !== actv) begin
			n_errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expv, actv);
		end
	endtask

	// send one command beat; entered and left at a falling edge
	task automatic send_cmd(cmd_t c, int idle, bit known, wheels_t typed);
		while ($urandom_range(0, 99) < idle) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_wheels.push_back(known ? typed : mix_wheels(c, cur_limit));
		n_cmds++;
		@(negedge clk);
	endtask

	// write the wheel limit once all results are in; falling edge to falling edge
	task automatic set_limit(logic [LIMIT_W-1:0] lim);
		start <= 1'b0;
		while (pending_wheels.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= lim;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cur_limit = lim;
		n_limits++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		wheels_t want;
		if (arst_n && done) begin
			n_results++;
			if (wheels.was_scaled)
				n_scaled++;
			if (pending_wheels.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected result beat, expected none, got %h", $time,
					wheels);
			end else begin
				want = pending_wheels.pop_front();
				check_field("wheel_one", want.wheel_one, wheels.wheel_one);
				check_field("wheel_two", want.wheel_two, wheels.wheel_two);
				check_field("wheel_three", want.wheel_three, wheels.wheel_three);
				check_field("wheel_four", want.wheel_four, wheels.wheel_four);
				check_field("was_scaled", want.was_scaled, wheels.was_scaled);
			end
		end
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// stimulus
	initial begin
		cmd_t    c;
		wheels_t typed;
		dir_row_t row;
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = '0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		cur_limit    = LIMIT_RESET;
		n_cmds       = 0;
		n_results    = 0;
		n_scaled     = 0;
		n_limits     = 0;
		n_errors     = 0;
		quiet_cycles = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed rows
		for (int i = 0; i < NUM_DIRECTED; i++) begin
			row = dir_tab[i];
			if (row.lim != cur_limit)
				set_limit(row.lim[LIMIT_W-1:0]);
			c.vel_forward       = row.fwd[CMD_W-1:0];
			c.vel_sideways      = row.side[CMD_W-1:0];
			c.rot_rate          = row.rot[CMD_W-1:0];
			typed.wheel_one     = row.w1[CMD_W-1:0];
			typed.wheel_two     = row.w2[CMD_W-1:0];
			typed.wheel_three   = row.w3[CMD_W-1:0];
			typed.wheel_four    = row.w4[CMD_W-1:0];
			typed.was_scaled    = row.sc;
			send_cmd(c, 0, row.known, typed);
		end

		// random phases, each with its limit write and its idle percentage from idle_pct
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: set_limit(LIMIT_RESET);
				1: set_limit('1);
				3: set_limit(LIMIT_W'($urandom_range(0, 255)));
				default: set_limit(LIMIT_W'($urandom_range(1, 32767)));
			endcase
			for (int k = 0; k < PHASE_CMDS; k++) begin
				c.vel_forward  = pick_vel(cur_limit);
				c.vel_sideways = pick_vel(cur_limit);
				c.rot_rate     = pick_vel(cur_limit);
				send_cmd(c, idle_pct[p], 1'b0, '0);
			end
		end
		start <= 1'b0;

		// drain the pipeline
		while (pending_wheels.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 5) @(posedge clk);

		$display("%0d commands sent, %0d results checked, %0d of them scaled",
			n_cmds, n_results, n_scaled);
		$display("%0d wheel limit writes, including 0, 1 and 32767", n_limits);
		if (n_errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== mecanum_wheel_mixer.f =====
hdl/mwm_pkg.sv
hdl/mwm_mix.sv
hdl/mwm_div.sv
hdl/mecanum_wheel_mixer.sv
tb/mecanum_wheel_mixer_tb.sv
